@@ src/cpi_pkg.sv @@
// Shared types and constants for the circle pair collision impulse block.
`timescale 1ns / 1ps
package cpi_pkg;

    // Pipelined divider geometry: numerator, divisor and quotient widths
    localparam int DIV_NUM_W = 58;
    localparam int DIV_DEN_W = 34;
    localparam int DIV_Q_W   = 29;

    // Restitution register reset (0.5 in Q1.8) and the 1.0 offset
    localparam logic [8:0] RESTITUTION_RST = 9'd128;
    localparam logic [9:0] E_ONE           = 10'd256;

    // One input transfer
    typedef struct packed {
        logic signed [15:0] pos_ax;
        logic signed [15:0] pos_ay;
        logic signed [15:0] pos_bx;
        logic signed [15:0] pos_by;
        logic signed [15:0] vel_ax;
        logic signed [15:0] vel_ay;
        logic signed [15:0] vel_bx;
        logic signed [15:0] vel_by;
        logic [15:0]        mass_a;
        logic [15:0]        mass_b;
        logic [14:0]        radius_a;
        logic [14:0]        radius_b;
    } t_in;

    // One result transfer
    typedef struct packed {
        logic signed [15:0] new_vel_ax;
        logic signed [15:0] new_vel_ay;
        logic signed [15:0] new_vel_bx;
        logic signed [15:0] new_vel_by;
        logic               in_contact;
        logic               impulse_applied;
        logic               saturated;
    } t_out;

    // Divider operands
    typedef struct packed {
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_in;

    // Sideband alongside the projection divide
    typedef struct packed {
        logic               valid;
        logic               contact;
        logic               apply;
        logic               neg_x;
        logic               neg_y;
        logic signed [15:0] vel_ax;
        logic signed [15:0] vel_ay;
        logic signed [15:0] vel_bx;
        logic signed [15:0] vel_by;
        logic [9:0]         ef;
        logic [15:0]        mass_a;
        logic [15:0]        mass_b;
        logic [16:0]        msum;
    } t_side1;

    // Sideband alongside the mass-ratio divide
    typedef struct packed {
        logic               valid;
        logic               contact;
        logic               apply;
        logic               neg_ax;
        logic               neg_ay;
        logic               neg_bx;
        logic               neg_by;
        logic signed [15:0] vel_ax;
        logic signed [15:0] vel_ay;
        logic signed [15:0] vel_bx;
        logic signed [15:0] vel_by;
    } t_side2;

endpackage

@@ src/circle_pair_collision_impulse.sv @@
// Throughput: one circle pair per cycle; busy is always low, and two chains
// of 29-stage restoring dividers set the depth.
// Reset: synchronous, clears all pipeline valid bits and sets restitution
// to 0.5; the result port has no back-pressure.
`timescale 1ns / 1ps
module circle_pair_collision_impulse (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  cpi_pkg::t_in  i_item,
    input  logic          i_cfg_we,
    input  logic [8:0]    i_cfg_data,
    output logic          o_valid,
    output cpi_pkg::t_out o_result
);
    import cpi_pkg::*;

    logic [8:0]          r_restitution;
    t_side1              w_side1;
    t_side2              w_side2;
    t_div_in             w_div_x, w_div_y;
    t_div_in             w_div_ax, w_div_ay, w_div_bx, w_div_by;
    logic [DIV_Q_W-1:0]  w_quot_x, w_quot_y;
    logic [DIV_Q_W-1:0]  w_quot_ax, w_quot_ay, w_quot_bx, w_quot_by;
    t_side1              r_dly1 [DIV_Q_W];
    t_side2              r_dly2 [DIV_Q_W];

    // pipeline never stalls
    assign busy = 1'b0;

    // restitution register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_restitution <= RESTITUTION_RST;
        end else if (i_cfg_we) begin
            r_restitution <= i_cfg_data;
        end
    end

    cpi_geom u_geom (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (start && !busy),
        .i_item        (i_item),
        .i_restitution (r_restitution),
        .o_side        (w_side1),
        .o_div_x       (w_div_x),
        .o_div_y       (w_div_y)
    );

    cpi_div u_div_x (.i_clk(i_clk), .i_div(w_div_x), .o_quot(w_quot_x));
    cpi_div u_div_y (.i_clk(i_clk), .i_div(w_div_y), .o_quot(w_quot_y));

    // sideband delay lines matching the divider depth
    always_ff @(posedge i_clk) begin
        r_dly1[0][$bits(t_side1)-2:0] <= w_side1[$bits(t_side1)-2:0];
        r_dly2[0][$bits(t_side2)-2:0] <= w_side2[$bits(t_side2)-2:0];
        for (int i = 1; i < DIV_Q_W; i++) begin
            r_dly1[i][$bits(t_side1)-2:0] <= r_dly1[i-1][$bits(t_side1)-2:0];
            r_dly2[i][$bits(t_side2)-2:0] <= r_dly2[i-1][$bits(t_side2)-2:0];
        end
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_Q_W; i++) begin
                r_dly1[i].valid <= 1'b0;
                r_dly2[i].valid <= 1'b0;
            end
        end else begin
            r_dly1[0].valid <= w_side1.valid;
            r_dly2[0].valid <= w_side2.valid;
            for (int i = 1; i < DIV_Q_W; i++) begin
                r_dly1[i].valid <= r_dly1[i-1].valid;
                r_dly2[i].valid <= r_dly2[i-1].valid;
            end
        end
    end

    cpi_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_side   (r_dly1[DIV_Q_W-1]),
        .i_quot_x (w_quot_x),
        .i_quot_y (w_quot_y),
        .o_side   (w_side2),
        .o_div_ax (w_div_ax),
        .o_div_ay (w_div_ay),
        .o_div_bx (w_div_bx),
        .o_div_by (w_div_by)
    );

    cpi_div u_div_ax (.i_clk(i_clk), .i_div(w_div_ax), .o_quot(w_quot_ax));
    cpi_div u_div_ay (.i_clk(i_clk), .i_div(w_div_ay), .o_quot(w_quot_ay));
    cpi_div u_div_bx (.i_clk(i_clk), .i_div(w_div_bx), .o_quot(w_quot_bx));
    cpi_div u_div_by (.i_clk(i_clk), .i_div(w_div_by), .o_quot(w_quot_by));

    cpi_update u_update (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_side    (r_dly2[DIV_Q_W-1]),
        .i_quot_ax (w_quot_ax),
        .i_quot_ay (w_quot_ay),
        .i_quot_bx (w_quot_bx),
        .i_quot_by (w_quot_by),
        .o_valid   (o_valid),
        .o_result  (o_result)
    );

endmodule

@@ src/cpi_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module cpi_div (
    input  logic                         i_clk,
    input  cpi_pkg::t_div_in             i_div,
    output logic [cpi_pkg::DIV_Q_W-1:0]  o_quot
);
    import cpi_pkg::*;

    logic [DIV_DEN_W-1:0] r_rem [DIV_Q_W];
    logic [DIV_Q_W-1:0]   r_low [DIV_Q_W];
    logic [DIV_DEN_W-1:0] r_den [DIV_Q_W];

    for (genvar g = 0; g < DIV_Q_W; g++) begin : g_stage
        logic [DIV_DEN_W-1:0] rem_in;
        logic [DIV_Q_W-1:0]   low_in;
        logic [DIV_DEN_W-1:0] den_in;
        logic [DIV_DEN_W:0]   trial;
        logic                 take;
        logic [DIV_DEN_W-1:0] n_rem;
        logic [DIV_Q_W-1:0]   n_low;

        // first stage takes the top numerator bits as partial remainder
        if (g == 0) begin : g_first
            assign rem_in = DIV_DEN_W'(i_div.num[DIV_NUM_W-1:DIV_Q_W]);
            assign low_in = i_div.num[DIV_Q_W-1:0];
            assign den_in = i_div.den;
        end else begin : g_next
            assign rem_in = r_rem[g-1];
            assign low_in = r_low[g-1];
            assign den_in = r_den[g-1];
        end

        // trial subtract; quotient bits shift in at the bottom
        assign trial = {rem_in, low_in[DIV_Q_W-1]};
        assign take  = trial >= {1'b0, den_in};
        assign n_rem = take ? DIV_DEN_W'(trial - {1'b0, den_in}) : trial[DIV_DEN_W-1:0];
        assign n_low = {low_in[DIV_Q_W-2:0], take};

        always_ff @(posedge i_clk) begin
            r_rem[g] <= n_rem;
            r_low[g] <= n_low;
            r_den[g] <= den_in;
        end
    end

    assign o_quot = r_low[DIV_Q_W-1];

endmodule

@@ src/cpi_geom.sv @@
// Front stages: offsets, products, contact test and projection divide operands.
`timescale 1ns / 1ps
module cpi_geom (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  cpi_pkg::t_in     i_item,
    input  logic [8:0]       i_restitution,
    output cpi_pkg::t_side1  o_side,
    output cpi_pkg::t_div_in o_div_x,
    output cpi_pkg::t_div_in o_div_y
);
    import cpi_pkg::*;

    t_side1 r_s1_side, r_s2_side, r_s3_side, r_s4_side, r_s5_side;
    t_side1 n_s1_side, n_s3_side, n_s5_side;

    logic signed [16:0] r_s1_dx, r_s1_dy, r_s1_rvx, r_s1_rvy;
    logic [15:0]        r_s1_rs;
    logic signed [33:0] r_s2_dxx, r_s2_dyy, r_s2_pdx, r_s2_pdy;
    logic [31:0]        r_s2_rsq;
    logic signed [16:0] r_s2_dx, r_s2_dy;
    logic [33:0]        r_s3_d2;
    logic signed [34:0] r_s3_dot;
    logic signed [16:0] r_s3_dx, r_s3_dy;
    logic signed [51:0] r_s4_nx, r_s4_ny;
    logic [33:0]        r_s4_d2;
    t_div_in            r_div_x, r_div_y;

    logic [33:0]        n_d2;
    logic signed [34:0] n_dot;
    logic               n_contact;
    logic [50:0]        n_absx, n_absy;

    // stage 1: differences and sideband capture
    always_comb begin
        n_s1_side         = '0;
        n_s1_side.valid   = i_take;
        n_s1_side.vel_ax  = i_item.vel_ax;
        n_s1_side.vel_ay  = i_item.vel_ay;
        n_s1_side.vel_bx  = i_item.vel_bx;
        n_s1_side.vel_by  = i_item.vel_by;
        n_s1_side.ef      = E_ONE + 10'(i_restitution);
        n_s1_side.mass_a  = i_item.mass_a;
        n_s1_side.mass_b  = i_item.mass_b;
        n_s1_side.msum    = 17'(i_item.mass_a) + 17'(i_item.mass_b);
    end

    // stage 3: squared distance, contact and approach test
    always_comb begin
        n_d2      = unsigned'(r_s2_dxx) + unsigned'(r_s2_dyy);
        n_dot     = 35'(r_s2_pdx) + 35'(r_s2_pdy);
        n_contact = n_d2 <= {2'b00, r_s2_rsq};
        n_s3_side = r_s2_side;
        n_s3_side.contact = n_contact;
        n_s3_side.apply   = n_contact && (n_d2 != '0) && n_dot[34]
                            && (r_s2_side.msum != '0);
    end

    // stage 5: magnitudes and rounding offset
    always_comb begin
        n_absx = r_s4_nx[51] ? 51'(-r_s4_nx) : 51'(r_s4_nx);
        n_absy = r_s4_ny[51] ? 51'(-r_s4_ny) : 51'(r_s4_ny);
        n_s5_side       = r_s4_side;
        n_s5_side.neg_x = r_s4_nx[51];
        n_s5_side.neg_y = r_s4_ny[51];
    end

    // payload and valid bits
    always_ff @(posedge i_clk) begin
        r_s1_side[$bits(t_side1)-2:0] <= n_s1_side[$bits(t_side1)-2:0];
        r_s1_dx  <= 17'(i_item.pos_ax) - 17'(i_item.pos_bx);
        r_s1_dy  <= 17'(i_item.pos_ay) - 17'(i_item.pos_by);
        r_s1_rvx <= 17'(i_item.vel_ax) - 17'(i_item.vel_bx);
        r_s1_rvy <= 17'(i_item.vel_ay) - 17'(i_item.vel_by);
        r_s1_rs  <= 16'(i_item.radius_a) + 16'(i_item.radius_b);

        r_s2_side[$bits(t_side1)-2:0] <= r_s1_side[$bits(t_side1)-2:0];
        r_s2_dxx <= r_s1_dx * r_s1_dx;
        r_s2_dyy <= r_s1_dy * r_s1_dy;
        r_s2_pdx <= r_s1_rvx * r_s1_dx;
        r_s2_pdy <= r_s1_rvy * r_s1_dy;
        r_s2_rsq <= r_s1_rs * r_s1_rs;
        r_s2_dx  <= r_s1_dx;
        r_s2_dy  <= r_s1_dy;

        r_s3_side[$bits(t_side1)-2:0] <= n_s3_side[$bits(t_side1)-2:0];
        r_s3_d2  <= n_d2;
        r_s3_dot <= n_dot;
        r_s3_dx  <= r_s2_dx;
        r_s3_dy  <= r_s2_dy;

        r_s4_side[$bits(t_side1)-2:0] <= r_s3_side[$bits(t_side1)-2:0];
        r_s4_nx  <= r_s3_dot * r_s3_dx;
        r_s4_ny  <= r_s3_dot * r_s3_dy;
        r_s4_d2  <= r_s3_d2;

        r_s5_side[$bits(t_side1)-2:0] <= n_s5_side[$bits(t_side1)-2:0];
        r_div_x.num <= (DIV_NUM_W'(n_absx) << 8) + DIV_NUM_W'(r_s4_d2 >> 1);
        r_div_x.den <= r_s4_d2;
        r_div_y.num <= (DIV_NUM_W'(n_absy) << 8) + DIV_NUM_W'(r_s4_d2 >> 1);
        r_div_y.den <= r_s4_d2;

        if (!i_rst_n) begin
            r_s1_side.valid <= 1'b0;
            r_s2_side.valid <= 1'b0;
            r_s3_side.valid <= 1'b0;
            r_s4_side.valid <= 1'b0;
            r_s5_side.valid <= 1'b0;
        end else begin
            r_s1_side.valid <= n_s1_side.valid;
            r_s2_side.valid <= r_s1_side.valid;
            r_s3_side.valid <= n_s3_side.valid;
            r_s4_side.valid <= r_s3_side.valid;
            r_s5_side.valid <= n_s5_side.valid;
        end
    end

    assign o_side  = r_s5_side;
    assign o_div_x = r_div_x;
    assign o_div_y = r_div_y;

endmodule

@@ src/cpi_scale.sv @@
// Middle stages: signed projection, restitution and mass products, second divide operands.
`timescale 1ns / 1ps
module cpi_scale (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cpi_pkg::t_side1             i_side,
    input  logic [cpi_pkg::DIV_Q_W-1:0] i_quot_x,
    input  logic [cpi_pkg::DIV_Q_W-1:0] i_quot_y,
    output cpi_pkg::t_side2             o_side,
    output cpi_pkg::t_div_in            o_div_ax,
    output cpi_pkg::t_div_in            o_div_ay,
    output cpi_pkg::t_div_in            o_div_bx,
    output cpi_pkg::t_div_in            o_div_by
);
    import cpi_pkg::*;

    t_side1             r_t1_side, r_t2_side, r_t3_side;
    t_side2             r_t4_side, n_t4_side;
    logic signed [25:0] r_t1_px, r_t1_py, n_px, n_py;
    logic signed [36:0] r_t2_ex, r_t2_ey;
    logic signed [53:0] r_t3_ax, r_t3_ay, r_t3_bx, r_t3_by;
    logic [52:0]        n_abs_ax, n_abs_ay, n_abs_bx, n_abs_by;
    logic [DIV_NUM_W-1:0] n_half;
    logic [DIV_DEN_W-1:0] n_den;
    t_div_in            r_div_ax, r_div_ay, r_div_bx, r_div_by;

    // signed projection from quotient magnitude
    always_comb begin
        n_px = i_side.neg_x ? -$signed(26'(i_quot_x)) : $signed(26'(i_quot_x));
        n_py = i_side.neg_y ? -$signed(26'(i_quot_y)) : $signed(26'(i_quot_y));
    end

    // operands of the mass-ratio divide
    always_comb begin
        n_abs_ax = r_t3_ax[53] ? 53'(-r_t3_ax) : 53'(r_t3_ax);
        n_abs_ay = r_t3_ay[53] ? 53'(-r_t3_ay) : 53'(r_t3_ay);
        n_abs_bx = r_t3_bx[53] ? 53'(-r_t3_bx) : 53'(r_t3_bx);
        n_abs_by = r_t3_by[53] ? 53'(-r_t3_by) : 53'(r_t3_by);
        n_half   = DIV_NUM_W'({r_t3_side.msum, 15'd0});
        n_den    = DIV_DEN_W'({r_t3_side.msum, 16'd0});
        n_t4_side         = '0;
        n_t4_side.valid   = r_t3_side.valid;
        n_t4_side.contact = r_t3_side.contact;
        n_t4_side.apply   = r_t3_side.apply;
        n_t4_side.neg_ax  = r_t3_ax[53];
        n_t4_side.neg_ay  = r_t3_ay[53];
        n_t4_side.neg_bx  = r_t3_bx[53];
        n_t4_side.neg_by  = r_t3_by[53];
        n_t4_side.vel_ax  = r_t3_side.vel_ax;
        n_t4_side.vel_ay  = r_t3_side.vel_ay;
        n_t4_side.vel_bx  = r_t3_side.vel_bx;
        n_t4_side.vel_by  = r_t3_side.vel_by;
    end

    // payload and valid bits
    always_ff @(posedge i_clk) begin
        r_t1_side[$bits(t_side1)-2:0] <= i_side[$bits(t_side1)-2:0];
        r_t1_px <= n_px;
        r_t1_py <= n_py;

        r_t2_side[$bits(t_side1)-2:0] <= r_t1_side[$bits(t_side1)-2:0];
        r_t2_ex <= r_t1_px * $signed({1'b0, r_t1_side.ef});
        r_t2_ey <= r_t1_py * $signed({1'b0, r_t1_side.ef});

        r_t3_side[$bits(t_side1)-2:0] <= r_t2_side[$bits(t_side1)-2:0];
        r_t3_ax <= r_t2_ex * $signed({1'b0, r_t2_side.mass_b});
        r_t3_ay <= r_t2_ey * $signed({1'b0, r_t2_side.mass_b});
        r_t3_bx <= r_t2_ex * $signed({1'b0, r_t2_side.mass_a});
        r_t3_by <= r_t2_ey * $signed({1'b0, r_t2_side.mass_a});

        r_t4_side[$bits(t_side2)-2:0] <= n_t4_side[$bits(t_side2)-2:0];
        r_div_ax.num <= DIV_NUM_W'(n_abs_ax) + n_half;
        r_div_ay.num <= DIV_NUM_W'(n_abs_ay) + n_half;
        r_div_bx.num <= DIV_NUM_W'(n_abs_bx) + n_half;
        r_div_by.num <= DIV_NUM_W'(n_abs_by) + n_half;
        r_div_ax.den <= n_den;
        r_div_ay.den <= n_den;
        r_div_bx.den <= n_den;
        r_div_by.den <= n_den;

        if (!i_rst_n) begin
            r_t1_side.valid <= 1'b0;
            r_t2_side.valid <= 1'b0;
            r_t3_side.valid <= 1'b0;
            r_t4_side.valid <= 1'b0;
        end else begin
            r_t1_side.valid <= i_side.valid;
            r_t2_side.valid <= r_t1_side.valid;
            r_t3_side.valid <= r_t2_side.valid;
            r_t4_side.valid <= n_t4_side.valid;
        end
    end

    assign o_side   = r_t4_side;
    assign o_div_ax = r_div_ax;
    assign o_div_ay = r_div_ay;
    assign o_div_bx = r_div_bx;
    assign o_div_by = r_div_by;

endmodule

@@ src/cpi_update.sv @@
// Final stage: velocity update, saturation and result register.
`timescale 1ns / 1ps
module cpi_update (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cpi_pkg::t_side2             i_side,
    input  logic [cpi_pkg::DIV_Q_W-1:0] i_quot_ax,
    input  logic [cpi_pkg::DIV_Q_W-1:0] i_quot_ay,
    input  logic [cpi_pkg::DIV_Q_W-1:0] i_quot_bx,
    input  logic [cpi_pkg::DIV_Q_W-1:0] i_quot_by,
    output logic                        o_valid,
    output cpi_pkg::t_out               o_result
);
    import cpi_pkg::*;

    logic               r_valid;
    t_out               r_result, n_result;
    logic signed [30:0] n_dv_ax, n_dv_ay, n_dv_bx, n_dv_by;
    logic signed [30:0] n_sum_ax, n_sum_ay, n_sum_bx, n_sum_by;
    logic [3:0]         n_clip;

    function automatic logic [16:0] sat16(input logic signed [30:0] v);
        logic [16:0] res;
        if (v > 31'sd32767) begin
            res = {1'b1, 16'h7FFF};
        end else if (v < -31'sd32768) begin
            res = {1'b1, 16'h8000};
        end else begin
            res = {1'b0, v[15:0]};
        end
        return res;
    endfunction

    // apply signed velocity change, clip to 16 bits
    always_comb begin
        n_dv_ax  = i_side.neg_ax ? -$signed(31'(i_quot_ax)) : $signed(31'(i_quot_ax));
        n_dv_ay  = i_side.neg_ay ? -$signed(31'(i_quot_ay)) : $signed(31'(i_quot_ay));
        n_dv_bx  = i_side.neg_bx ? -$signed(31'(i_quot_bx)) : $signed(31'(i_quot_bx));
        n_dv_by  = i_side.neg_by ? -$signed(31'(i_quot_by)) : $signed(31'(i_quot_by));
        n_sum_ax = 31'(i_side.vel_ax) - n_dv_ax;
        n_sum_ay = 31'(i_side.vel_ay) - n_dv_ay;
        n_sum_bx = 31'(i_side.vel_bx) + n_dv_bx;
        n_sum_by = 31'(i_side.vel_by) + n_dv_by;
        n_result = '0;
        n_result.in_contact      = i_side.contact;
        n_result.impulse_applied = i_side.apply;
        if (i_side.apply) begin
            {n_clip[0], n_result.new_vel_ax} = sat16(n_sum_ax);
            {n_clip[1], n_result.new_vel_ay} = sat16(n_sum_ay);
            {n_clip[2], n_result.new_vel_bx} = sat16(n_sum_bx);
            {n_clip[3], n_result.new_vel_by} = sat16(n_sum_by);
        end else begin
            n_clip              = '0;
            n_result.new_vel_ax = i_side.vel_ax;
            n_result.new_vel_ay = i_side.vel_ay;
            n_result.new_vel_bx = i_side.vel_bx;
            n_result.new_vel_by = i_side.vel_by;
        end
        n_result.saturated = |n_clip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ dv/circle_pair_collision_impulse_chk.sv @@
// Checker: watches the circle pair transfers, predicts new velocities and compares.
`timescale 1ns / 1ps
module circle_pair_collision_impulse_chk (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  logic          busy,
    input  cpi_pkg::t_in  i_item,
    input  logic          i_cfg_we,
    input  logic [8:0]    i_cfg_data,
    input  logic          o_valid,
    input  cpi_pkg::t_out o_result,
    output int            o_fail_count,
    output int            o_pending
);
    import cpi_pkg::*;

    logic [8:0] restitution_q;
    t_out       expected_vels[$];
    int         mismatch_count;

    // Round n/d to nearest, ties away from zero
    function automatic longint round_div(longint n, longint d);
        longint mag;
        longint q;
        mag = (n < 0) ? -n : n;
        q = (mag + d / 2) / d;
        return (n < 0) ? -q : q;
    endfunction

    // Clip to 16 bits signed, noting any clip
    function automatic logic signed [15:0] clip16(longint v, inout logic clipped);
        if (v > 32767) begin
            clipped = 1'b1;
            return 16'sh7fff;
        end
        if (v < -32768) begin
            clipped = 1'b1;
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    function automatic t_out resolve_pair(t_in p, logic [8:0] e);
        t_out   r;
        longint dx, dy, d2, rs, rvx, rvy, dot, msum, projx, projy, ef, den;
        longint nax, nay, nbx, nby;
        logic   contact, apply, clipped;
        dx = longint'(p.pos_ax) - longint'(p.pos_bx);
        dy = longint'(p.pos_ay) - longint'(p.pos_by);
        d2 = dx * dx + dy * dy;
        rs = longint'(p.radius_a) + longint'(p.radius_b);
        contact = d2 <= rs * rs;
        rvx = longint'(p.vel_ax) - longint'(p.vel_bx);
        rvy = longint'(p.vel_ay) - longint'(p.vel_by);
        dot = rvx * dx + rvy * dy;
        msum = longint'(p.mass_a) + longint'(p.mass_b);
        apply = contact && d2 != 0 && dot < 0 && msum != 0;
        nax = p.vel_ax;
        nay = p.vel_ay;
        nbx = p.vel_bx;
        nby = p.vel_by;
        if (apply) begin
            projx = round_div(dot * dx * 256, d2);
            projy = round_div(dot * dy * 256, d2);
            ef = 256 + longint'(e);
            den = msum << 16;
            nax = nax - round_div(projx * ef * longint'(p.mass_b), den);
            nay = nay - round_div(projy * ef * longint'(p.mass_b), den);
            nbx = nbx + round_div(projx * ef * longint'(p.mass_a), den);
            nby = nby + round_div(projy * ef * longint'(p.mass_a), den);
        end
        clipped = 1'b0;
        r.new_vel_ax = clip16(nax, clipped);
        r.new_vel_ay = clip16(nay, clipped);
        r.new_vel_bx = clip16(nbx, clipped);
        r.new_vel_by = clip16(nby, clipped);
        r.in_contact = contact;
        r.impulse_applied = apply;
        r.saturated = clipped;
        return r;
    endfunction

    assign o_fail_count = mismatch_count;
    assign o_pending = expected_vels.size();

    // Restitution mirror, prediction on input transfer, compare on result
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            restitution_q <= RESTITUTION_RST;
            expected_vels.delete();
            mismatch_count <= 0;
        end else begin
            if (i_cfg_we)
                restitution_q <= i_cfg_data;
            if (start && !busy)
                expected_vels.push_back(resolve_pair(i_item, restitution_q));
            if (o_valid) begin
                if (expected_vels.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected result %h", o_result);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    want = expected_vels.pop_front();
                    if (want !== o_result) begin
                        if (mismatch_count < 10)
                            $display("mismatch: exp vA=(%0d,%0d) vB=(%0d,%0d) c%b i%b s%b, got vA=(%0d,%0d) vB=(%0d,%0d) c%b i%b s%b",
                                want.new_vel_ax, want.new_vel_ay, want.new_vel_bx,
                                want.new_vel_by, want.in_contact, want.impulse_applied,
                                want.saturated, o_result.new_vel_ax, o_result.new_vel_ay,
                                o_result.new_vel_bx, o_result.new_vel_by,
                                o_result.in_contact, o_result.impulse_applied,
                                o_result.saturated);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
        end
    end
endmodule

@@ dv/circle_pair_collision_impulse_tb.sv @@
// Testbench top: drives circle pairs and restitution settings and gives the verdict.
`timescale 1ns / 1ps
module circle_pair_collision_impulse_tb;
    import cpi_pkg::*;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    t_in        i_item = '0;
    logic       i_cfg_we = 1'b0;
    logic [8:0] i_cfg_data = '0;
    logic       o_valid;
    t_out       o_result;
    int         fail_count;
    int         pending;
    int         idle_pct;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    circle_pair_collision_impulse i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_result(o_result)
    );

    circle_pair_collision_impulse_chk i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_result(o_result),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Offer one pair, holding start until the transfer
    task automatic send_pair(t_in p);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_item <= p;
        do @(posedge i_clk); while (busy);
    endtask

    // Drain results and the pipeline, then write restitution
    task automatic set_restitution(logic [8:0] e);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= e;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_in rand_pair(bit colliding);
        t_in p;
        int  s;
        p = $bits(t_in)'({$urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom});
        if (colliding) begin
            // Nearby centres, radii on the scale of the gap, mostly moderate random velocities
            s = 1 << $urandom_range(14, 4);
            p.pos_bx = p.pos_ax + 16'($signed($urandom_range(2 * s)) - s);
            p.pos_by = p.pos_ay + 16'($signed($urandom_range(2 * s)) - s);
            p.radius_a = 15'($urandom_range(2 * s));
            p.radius_b = 15'($urandom_range(2 * s));
            if ($urandom_range(3) != 0) begin
                p.vel_ax = 16'($signed($urandom_range(8000)) - 4000);
                p.vel_ay = 16'($signed($urandom_range(8000)) - 4000);
                p.vel_bx = 16'($signed($urandom_range(8000)) - 4000);
                p.vel_by = 16'($signed($urandom_range(8000)) - 4000);
            end
        end
        if ($urandom_range(9) == 0) p.mass_a = 16'($urandom_range(1));
        if ($urandom_range(9) == 0) p.mass_b = 16'($urandom_range(1));
        if ($urandom_range(7) == 0) p.mass_a = 16'hffff;
        return p;
    endfunction

    initial begin
        t_in         p;
        logic [8:0]  settings[6];
        settings = '{9'd0, 9'd256, 9'd511, 9'd128, 9'd64, 9'd300};
        idle_pct = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: head-on, coincident, no contact, extremes, zero masses
        p = '0;
        p.pos_ax = 16'sd100; p.vel_ax = -16'sd1000; p.vel_bx = 16'sd1000;
        p.mass_a = 16'd256; p.mass_b = 16'd256; p.radius_a = 15'd60; p.radius_b = 15'd60;
        send_pair(p);
        p.vel_ax = 16'sd1000; p.vel_bx = -16'sd1000;
        send_pair(p);
        p.pos_ax = 16'sd0;
        send_pair(p);
        p.pos_ax = 16'sd1000; p.radius_a = 15'd1; p.radius_b = 15'd1;
        send_pair(p);
        p = '0;
        p.pos_ax = 16'sh7fff; p.pos_ay = 16'sh7fff; p.pos_bx = 16'sh8000;
        p.pos_by = 16'sh8000; p.vel_ax = 16'sh8000; p.vel_ay = 16'sh8000;
        p.vel_bx = 16'sh7fff; p.vel_by = 16'sh7fff; p.mass_a = 16'hffff;
        p.mass_b = 16'hffff; p.radius_a = 15'h7fff; p.radius_b = 15'h7fff;
        send_pair(p);
        p.mass_a = 16'd0;
        send_pair(p);
        p.mass_b = 16'd0;
        send_pair(p);
        p.mass_a = 16'd1; p.mass_b = 16'd0;
        send_pair(p);
        p = '1;
        send_pair(p);
        p.pos_ax = 16'sd50; p.pos_bx = -16'sd50; p.vel_ax = -16'sd2000;
        p.vel_bx = 16'sd2000; p.pos_ay = 16'sd0; p.pos_by = 16'sd0;
        p.vel_ay = 16'sd0; p.vel_by = 16'sd0;
        p.mass_a = 16'd1; p.mass_b = 16'hffff;
        send_pair(p);
        set_restitution(9'd511);
        send_pair(p);

        // Random phases over restitution settings and idling levels
        for (int ph = 0; ph < 6; ph++) begin
            set_restitution(settings[ph]);
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 80;
                2: idle_pct = 0;
                default: idle_pct = 13;
            endcase
            repeat (125) send_pair(rand_pair($urandom_range(4) != 0));
        end
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("** circle_pair_collision_impulse: PASSED **");
        end else begin
            $display("** circle_pair_collision_impulse: FAILED **");
        end
        $finish;
    end

    // Run limit
    initial begin
        #2000000;
        $display("** circle_pair_collision_impulse: FAILED **");
        $finish;
    end
endmodule

@@ sim.f @@
src/cpi_pkg.sv
src/cpi_div.sv
src/cpi_geom.sv
src/cpi_scale.sv
src/cpi_update.sv
src/circle_pair_collision_impulse.sv
dv/circle_pair_collision_impulse_chk.sv
dv/circle_pair_collision_impulse_tb.sv
